// File: hdl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared widths, register indexes, level codes and pipeline stage types for
// the memory pressure classifier.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int unsigned BytesW   = 48;
  localparam int unsigned UsageW   = BytesW + 2;  // sum of three 48-bit counts
  localparam int unsigned ThreshW  = BytesW + 1;  // sum of two 48-bit values
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 5 * BytesW;
  localparam int unsigned OutDataW = 56;           // 54 bits of fields, padded

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOFT_TARGET     = 2'd0,
    CFG_DEFAULT_RESERVE = 2'd1,
    CFG_FREEZE_BELOW    = 2'd2,
    CFG_UNUSED          = 2'd3
  } mpc_cfg_idx_e;

  typedef enum logic [1:0] {
    LVL_NORMAL      = 2'd0,
    LVL_CONSTRAINED = 2'd1,
    LVL_CRITICAL    = 2'd2,
    LVL_EMERGENCY   = 2'd3
  } mpc_level_e;

  typedef struct packed {
    logic [BytesW-1:0] resident;
    logic [BytesW-1:0] retire;
    logic [BytesW-1:0] transient;
    logic [BytesW-1:0] headroom;
    logic [BytesW-1:0] override_r;
  } mpc_in_t;

  typedef struct packed {
    logic [UsageW-1:0]  usage;
    logic [BytesW-1:0]  headroom;
    logic [BytesW-1:0]  reserve;
    logic [BytesW-2:0]  half;
    logic [ThreshW-1:0] crit_thr;   // target + half reserve
    logic [ThreshW-1:0] emer_thr;   // target + reserve
    logic [ThreshW-1:0] head_thr;   // reserve + half reserve
  } mpc_sum_t;

  typedef struct packed {
    logic [BytesW-1:0] reserve_in_use;
    logic              freeze;
    logic              shed;
    logic              reclaim;
    logic              allow;
    mpc_level_e        level;
  } mpc_out_t;

endpackage

// File: hdl/memory_pressure_classifier_top.sv
// ----------------------------------------------------------------------------
// memory_pressure_classifier_top
// Classifies memory pressure from usage and headroom counts per word.
// ----------------------------------------------------------------------------
// structure: input register, then sums, compares and flag decode feeding the
// output register
// throughput: one word per cycle; each register advances when the next is free
// reset: asynchronous, clears all configuration registers and stage valids
// ----------------------------------------------------------------------------
module memory_pressure_classifier_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [mpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mpc_pkg::BytesW-1:0]       cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // resident, retire_pending, transient, headroom, reserve_override (48 each)
  input  logic [mpc_pkg::InDataW-1:0]      s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pressure_level[1:0], allow_opportunistic, request_reclaim,
  // shed_noncritical, freeze_opportunistic, reserve_in_use[47:0], pad[1:0]
  output logic [mpc_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned BW = mpc_pkg::BytesW;

  // configuration
  logic [BW-1:0] soft_target_q;
  logic [BW-1:0] def_reserve_q;
  logic          freeze_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_target_q <= '0;
      def_reserve_q <= '0;
      freeze_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (mpc_pkg::mpc_cfg_idx_e'(cfg_idx_i))
        mpc_pkg::CFG_SOFT_TARGET:     soft_target_q <= cfg_data_i;
        mpc_pkg::CFG_DEFAULT_RESERVE: def_reserve_q <= cfg_data_i;
        mpc_pkg::CFG_FREEZE_BELOW:    freeze_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v0_q, v1_q;
  logic rdy0, rdy1;

  assign rdy1 = !v1_q || m_axis_tready;
  assign rdy0 = !v0_q || rdy1;

  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
    end
  end

  // stage 0: input register
  mpc_pkg::mpc_in_t in_d, in_q;

  always_comb begin
    in_d.resident   = s_axis_tdata[0*BW +: BW];
    in_d.retire     = s_axis_tdata[1*BW +: BW];
    in_d.transient  = s_axis_tdata[2*BW +: BW];
    in_d.headroom   = s_axis_tdata[3*BW +: BW];
    in_d.override_r = s_axis_tdata[4*BW +: BW];
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) in_q <= in_d;
  end

  // usage sum, reserve select and thresholds
  mpc_pkg::mpc_sum_t sums;
  logic [BW-1:0]     reserve_sel;

  always_comb begin
    reserve_sel    = (in_q.override_r != '0) ? in_q.override_r : def_reserve_q;
    sums.usage     = {2'b00, in_q.resident} + {2'b00, in_q.retire}
                   + {2'b00, in_q.transient};
    sums.headroom  = in_q.headroom;
    sums.reserve   = reserve_sel;
    sums.half      = reserve_sel[BW-1:1];
    sums.crit_thr  = {1'b0, soft_target_q} + {2'b00, reserve_sel[BW-1:1]};
    sums.emer_thr  = {1'b0, soft_target_q} + {1'b0, reserve_sel};
    sums.head_thr  = {1'b0, reserve_sel} + {2'b00, reserve_sel[BW-1:1]};
  end

  // compares and flag decode into the output register
  mpc_pkg::mpc_out_t  out_d, out_q;
  mpc_pkg::mpc_level_e usage_lvl, head_lvl, worst_lvl;
  logic               res_nz, frz_hit;

  always_comb begin
    res_nz = (sums.reserve != '0);

    if (sums.usage >= {1'b0, sums.emer_thr}) begin
      usage_lvl = mpc_pkg::LVL_EMERGENCY;
    end else if (sums.usage >= {1'b0, sums.crit_thr}) begin
      usage_lvl = mpc_pkg::LVL_CRITICAL;
    end else if (sums.usage >= {2'b00, soft_target_q}) begin
      usage_lvl = mpc_pkg::LVL_CONSTRAINED;
    end else begin
      usage_lvl = mpc_pkg::LVL_NORMAL;
    end

    if (!res_nz) begin
      head_lvl = mpc_pkg::LVL_NORMAL;
    end else if (sums.headroom <= {1'b0, sums.half}) begin
      head_lvl = mpc_pkg::LVL_EMERGENCY;
    end else if (sums.headroom <= sums.reserve) begin
      head_lvl = mpc_pkg::LVL_CRITICAL;
    end else if ({1'b0, sums.headroom} <= sums.head_thr) begin
      head_lvl = mpc_pkg::LVL_CONSTRAINED;
    end else begin
      head_lvl = mpc_pkg::LVL_NORMAL;
    end

    worst_lvl = (usage_lvl >= head_lvl) ? usage_lvl : head_lvl;
    frz_hit   = freeze_en_q && res_nz && (sums.headroom <= sums.reserve);

    out_d.reserve_in_use = sums.reserve;
    out_d.level          = mpc_pkg::LVL_NORMAL;
    out_d.allow          = 1'b1;
    out_d.reclaim        = 1'b0;
    out_d.shed           = 1'b0;
    out_d.freeze         = 1'b0;

    // zero soft target disables classification
    if (soft_target_q != '0) begin
      out_d.level = worst_lvl;
      case (worst_lvl)
        mpc_pkg::LVL_EMERGENCY: begin
          out_d.allow   = 1'b0;
          out_d.reclaim = 1'b1;
          out_d.shed    = 1'b1;
        end
        mpc_pkg::LVL_CRITICAL: begin
          out_d.allow   = 1'b0;
          out_d.reclaim = 1'b1;
        end
        mpc_pkg::LVL_CONSTRAINED: begin
          out_d.reclaim = 1'b1;
        end
        default: ;
      endcase
      if (frz_hit) begin
        out_d.allow   = 1'b0;
        out_d.freeze  = 1'b1;
        out_d.reclaim = 1'b1;
        if (worst_lvl == mpc_pkg::LVL_NORMAL) out_d.level = mpc_pkg::LVL_CONSTRAINED;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) out_q <= out_d;
  end

  assign m_axis_tdata = {2'b00, out_q.reserve_in_use, out_q.freeze, out_q.shed,
                         out_q.reclaim, out_q.allow, out_q.level};

  // checks
  a_accept_fills_stage0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v0_q)
    else $error("accepted word did not reach input register");

  a_freeze_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.freeze |-> out_q.reclaim && !out_q.allow
                                      && out_q.level != mpc_pkg::LVL_NORMAL)
    else $error("freeze without reclaim, or with normal level");

  a_shed_is_emergency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.shed |-> out_q.level == mpc_pkg::LVL_EMERGENCY)
    else $error("shed outside emergency level");

  a_normal_allows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.level == mpc_pkg::LVL_NORMAL |-> out_q.allow && !out_q.reclaim)
    else $error("normal level with restricted flags");

  a_stage0_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && rdy1 |=> v1_q)
    else $error("input register word lost on advance");

endmodule
